[rtl/ile_pkg.sv]
// Shared types, codes and control store for the indexed list engine.
// No dependencies; compiled first.
package ile_pkg;

	localparam int CAPACITY_DEF    = 32;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int POS_WIDTH       = 6;
	localparam int OPCODE_WIDTH    = 3;
	localparam int STATUS_WIDTH    = 2;
	localparam int STEP_WIDTH      = 5;

	typedef enum logic [OPCODE_WIDTH-1:0] {
		OP_HEAD_INS  = 3'd0,
		OP_TAIL_INS  = 3'd1,
		OP_INSERT_AT = 3'd2,
		OP_DELETE_AT = 3'd3,
		OP_READ_AT   = 3'd4,
		OP_CLEAR     = 3'd5,
		OP_LENGTH    = 3'd6
	} op_t;

	typedef enum logic [STATUS_WIDTH-1:0] {
		ST_OK            = 2'd0,
		ST_BAD_INDEX     = 2'd1,
		ST_EMPTY_REFUSED = 2'd2,
		ST_FULL          = 2'd3
	} status_t;

	// Microprogram step labels, in control store order.
	typedef enum logic [STEP_WIDTH-1:0] {
		S_IDLE, S_DECODE,
		S_ALLOC, S_SETNEW, S_IWS, S_IWL, S_INS_M1, S_INS_M2, S_INS_HEAD,
		S_DEL, S_DWS, S_DWL, S_DEL_M1, S_DEL_M2, S_DEL_HEAD,
		S_RWS, S_RWL, S_RD_TAKE,
		S_CLR, S_RESP
	} step_t;

	// Datapath actions.
	typedef enum logic [3:0] {
		A_IDLE, A_DECODE, A_ALLOC, A_SETNEW, A_WSTART, A_WSTEP,
		A_INS_M1, A_INS_M2, A_INS_HEAD, A_RD_FIRST, A_DEL_M1, A_DEL_M2,
		A_DEL_HEAD, A_TAKE_RV, A_CLEAR, A_RESP
	} act_t;

	// Sequencing: next, goto, branch (else next), hold (else stay), dispatch.
	typedef enum logic [2:0] {
		C_NEXT, C_GOTO, C_BR, C_HOLD, C_DISPATCH
	} cond_t;

	typedef enum logic [2:0] {
		F_NONE, F_IN_FIRE, F_EP_ZERO, F_T_ZERO, F_K_ZERO, F_OUT_FREE
	} flag_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		flag_t flag;
		step_t target;
	} ucw_t;

	typedef struct packed {
		logic  in_fire;
		logic  ep_zero;
		logic  t_zero;
		logic  k_zero;
		logic  out_free;
		step_t dispatch;
	} seq_flags_t;

	// Control store.
	function automatic ucw_t ucode(input step_t s);
		ucw_t w;
		case (s)
			S_IDLE:     w = '{A_IDLE,     C_HOLD,     F_IN_FIRE,  S_DECODE};
			S_DECODE:   w = '{A_DECODE,   C_DISPATCH, F_NONE,     S_IDLE};
			S_ALLOC:    w = '{A_ALLOC,    C_NEXT,     F_NONE,     S_IDLE};
			S_SETNEW:   w = '{A_SETNEW,   C_BR,       F_EP_ZERO,  S_INS_HEAD};
			S_IWS:      w = '{A_WSTART,   C_BR,       F_T_ZERO,   S_INS_M1};
			S_IWL:      w = '{A_WSTEP,    C_HOLD,     F_K_ZERO,   S_INS_M1};
			S_INS_M1:   w = '{A_INS_M1,   C_NEXT,     F_NONE,     S_IDLE};
			S_INS_M2:   w = '{A_INS_M2,   C_GOTO,     F_NONE,     S_RESP};
			S_INS_HEAD: w = '{A_INS_HEAD, C_GOTO,     F_NONE,     S_RESP};
			S_DEL:      w = '{A_RD_FIRST, C_BR,       F_EP_ZERO,  S_DEL_HEAD};
			S_DWS:      w = '{A_WSTART,   C_BR,       F_T_ZERO,   S_DEL_M1};
			S_DWL:      w = '{A_WSTEP,    C_HOLD,     F_K_ZERO,   S_DEL_M1};
			S_DEL_M1:   w = '{A_DEL_M1,   C_NEXT,     F_NONE,     S_IDLE};
			S_DEL_M2:   w = '{A_DEL_M2,   C_GOTO,     F_NONE,     S_RESP};
			S_DEL_HEAD: w = '{A_DEL_HEAD, C_GOTO,     F_NONE,     S_RESP};
			S_RWS:      w = '{A_WSTART,   C_BR,       F_T_ZERO,   S_RD_TAKE};
			S_RWL:      w = '{A_WSTEP,    C_HOLD,     F_K_ZERO,   S_RD_TAKE};
			S_RD_TAKE:  w = '{A_TAKE_RV,  C_GOTO,     F_NONE,     S_RESP};
			S_CLR:      w = '{A_CLEAR,    C_GOTO,     F_NONE,     S_RESP};
			S_RESP:     w = '{A_RESP,     C_HOLD,     F_OUT_FREE, S_IDLE};
			default:    w = '{A_IDLE,     C_GOTO,     F_NONE,     S_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/ile_if.sv]
// Request and response channels of the indexed list engine.
// Depends on ile_pkg.
interface ile_req_if
	import ile_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic [OPCODE_WIDTH-1:0]       opcode;
	logic [POS_WIDTH-1:0]          position;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source(output valid, opcode, position, value, input ready);
	modport sink(input valid, opcode, position, value, output ready);
endinterface

interface ile_rsp_if
	import ile_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = $clog2(CAPACITY_DEF + 1)
) ();
	logic                          valid;
	logic                          ready;
	logic [STATUS_WIDTH-1:0]       status;
	logic signed [VALUE_WIDTH-1:0] read_value;
	logic [COUNT_WIDTH-1:0]        count;

	modport source(output valid, status, read_value, count, input ready);
	modport sink(input valid, status, read_value, count, output ready);
endinterface

[rtl/ile_ram.sv]
// Generic single write port RAM with one registered read port.
// No dependencies.
module ile_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ile_useq.sv]
// Microsequencer: step counter, control store lookup and next-step select.
// Depends on ile_pkg.
module ile_useq
	import ile_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  seq_flags_t flags,
	output ucw_t       cw,
	output step_t      step
);

	step_t upc_q;
	step_t upc_next;
	logic  flag_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= S_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	always_comb begin
		cw   = ucode(upc_q);
		step = upc_q;
		case (cw.flag)
			F_IN_FIRE:  flag_sel = flags.in_fire;
			F_EP_ZERO:  flag_sel = flags.ep_zero;
			F_T_ZERO:   flag_sel = flags.t_zero;
			F_K_ZERO:   flag_sel = flags.k_zero;
			F_OUT_FREE: flag_sel = flags.out_free;
			default:    flag_sel = 1'b0;
		endcase
		case (cw.cond)
			C_NEXT:     upc_next = step_t'(upc_q + STEP_WIDTH'(1));
			C_GOTO:     upc_next = cw.target;
			C_BR:       upc_next = flag_sel ? cw.target : step_t'(upc_q + STEP_WIDTH'(1));
			C_HOLD:     upc_next = flag_sel ? cw.target : upc_q;
			C_DISPATCH: upc_next = flags.dispatch;
			default:    upc_next = S_IDLE;
		endcase
	end

endmodule

[rtl/indexed_list_engine_unit.sv]
// Indexed list engine, one item at a time. A tail insert walks to position count-1; the walk
// follows one link per cycle through the link RAM's registered read.
// A new item is taken while the previous result still waits in the output register.
// Reset (async, active low): list empty, no result pending; RAMs are not cleared.
module indexed_list_engine_unit
	import ile_pkg::*;
#(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ile_req_if.sink  req,
	ile_rsp_if.source rsp
);

	localparam int SW = $clog2(CAPACITY);      // slot index
	localparam int CW = $clog2(CAPACITY + 1);  // count, 0..CAPACITY
	localparam int XW = (POS_WIDTH > CW) ? POS_WIDTH : CW;

	// Sequencer interface
	ucw_t       cw;
	step_t      step;
	seq_flags_t flags;

	// List bookkeeping (control, reset)
	logic [CW-1:0] cnt_q;    // entries in the list
	logic [SW-1:0] first_q;  // slot of position 0
	logic [CW-1:0] hwm_q;    // slots below this have been handed out at least once
	logic [CW-1:0] sp_q;     // depth of the free-slot stack
	logic          out_valid_q;

	// Item and walk registers (payload, no reset)
	op_t              op_q;
	logic [POS_WIDTH-1:0] pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	status_t          status_q;
	logic             ep0_q;   // effective position is zero
	logic [CW-1:0]    wt_q;    // walk target position
	logic [CW-1:0]    k_q;     // links left to follow
	logic [SW-1:0]    cur_q;   // slot reached by the walk
	logic [SW-1:0]    new_q;   // allocated slot on insert, victim slot on delete
	logic             pop_q;   // allocation came from the free stack
	logic [VALUE_WIDTH-1:0] rv_q;
	status_t          out_status_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [CW-1:0]    out_count_q;

	// Decode
	logic [XW-1:0] pos_x, cnt_x, ep, ep_m1;
	logic          full, rd_op;
	status_t       dec_status;
	step_t         dec_step;
	logic [CW-1:0] dec_wt;

	// RAM ports
	logic [SW-1:0]          rd_addr;
	logic                   link_we;
	logic [SW-1:0]          link_waddr, link_wdata, link_rdata;
	logic                   val_we;
	logic [VALUE_WIDTH-1:0] val_rdata;
	logic                   fs_we;
	logic [SW-1:0]          fs_waddr, fs_wdata, fs_raddr, fs_rdata;
	logic [CW-1:0]          sp_m1;

	logic in_fire, out_free, resp_load;

	assign in_fire   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign resp_load = (cw.act == A_RESP) && out_free;
	assign sp_m1     = sp_q - CW'(1);

	assign req.ready      = (step == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_value_q;
	assign rsp.count      = out_count_q;

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	always_comb begin
		flags.in_fire  = in_fire;
		flags.ep_zero  = ep0_q;
		flags.t_zero   = (wt_q == '0);
		flags.k_zero   = (k_q == '0);
		flags.out_free = out_free;
		flags.dispatch = dec_step;
	end

	ile_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw),
		.step   (step)
	);

	//------------------------------------------------------------------
	// Storage: values, links, and the stack of released slots
	//------------------------------------------------------------------
	ile_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (new_q),
		.wdata (val_q),
		.raddr (rd_addr),
		.rdata (val_rdata)
	);

	ile_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	ile_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fs_waddr),
		.wdata (fs_wdata),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	//------------------------------------------------------------------
	// Decode: range checks, refusals and routine select.
	// Head/tail inserts into an empty list are refused; for insert at,
	// a bad position wins over full.
	//------------------------------------------------------------------
	always_comb begin
		pos_x      = XW'(pos_q);
		cnt_x      = XW'(cnt_q);
		full       = (cnt_q == CW'(CAPACITY));
		ep         = '0;
		rd_op      = 1'b0;
		dec_status = ST_OK;
		dec_step   = S_RESP;
		case (op_q)
			OP_HEAD_INS: begin
				if (cnt_q == '0) dec_status = ST_EMPTY_REFUSED;
				else if (full) dec_status = ST_FULL;
				else dec_step = S_ALLOC;
			end
			OP_TAIL_INS: begin
				ep = cnt_x;
				if (cnt_q == '0) dec_status = ST_EMPTY_REFUSED;
				else if (full) dec_status = ST_FULL;
				else dec_step = S_ALLOC;
			end
			OP_INSERT_AT: begin
				ep = pos_x;
				if (pos_x > cnt_x) dec_status = ST_BAD_INDEX;
				else if (full) dec_status = ST_FULL;
				else dec_step = S_ALLOC;
			end
			OP_DELETE_AT: begin
				ep = pos_x;
				if (pos_x >= cnt_x) dec_status = ST_BAD_INDEX;
				else dec_step = S_DEL;
			end
			OP_READ_AT: begin
				ep    = pos_x;
				rd_op = 1'b1;
				if (pos_x >= cnt_x) dec_status = ST_BAD_INDEX;
				else dec_step = S_RWS;
			end
			OP_CLEAR: dec_step = S_CLR;
			default: ;  // length report and the unused code
		endcase
		// Reads walk to the entry itself, inserts and deletes to its predecessor.
		ep_m1  = ep - XW'(1);
		dec_wt = rd_op ? ep[CW-1:0] : ep_m1[CW-1:0];
	end

	//------------------------------------------------------------------
	// RAM control. One shared read address feeds value and link RAMs, so
	// after a walk both read data outputs show the entry at cur_q.
	//------------------------------------------------------------------
	always_comb begin
		rd_addr    = cur_q;
		link_we    = 1'b0;
		link_waddr = new_q;
		link_wdata = link_rdata;
		val_we     = 1'b0;
		fs_we      = 1'b0;
		fs_waddr   = sp_q[SW-1:0];
		fs_wdata   = new_q;
		fs_raddr   = sp_m1[SW-1:0];
		case (cw.act)
			A_WSTEP:    rd_addr = link_rdata;
			A_RD_FIRST: rd_addr = first_q;
			A_DEL_M1:   rd_addr = link_rdata;
			A_INS_M1: begin
				// new entry takes over the successor of its predecessor
				link_we = 1'b1;
				val_we  = 1'b1;
			end
			A_INS_M2: begin
				link_we    = 1'b1;
				link_waddr = cur_q;
				link_wdata = new_q;
			end
			A_INS_HEAD: begin
				link_we    = 1'b1;
				link_wdata = first_q;
				val_we     = 1'b1;
			end
			A_DEL_HEAD: begin
				fs_we    = 1'b1;
				fs_wdata = first_q;
			end
			A_DEL_M2: begin
				// predecessor skips the victim; victim goes back on the stack
				link_we    = 1'b1;
				link_waddr = cur_q;
				fs_we      = 1'b1;
			end
			default: ;
		endcase
	end

	//------------------------------------------------------------------
	// List bookkeeping and output handshake
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			first_q     <= '0;
			hwm_q       <= '0;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cw.act)
				A_ALLOC: begin
					// reuse a released slot first, else a never-used one
					if (sp_q != '0) sp_q <= sp_m1;
					else hwm_q <= hwm_q + CW'(1);
				end
				A_INS_M2: cnt_q <= cnt_q + CW'(1);
				A_INS_HEAD: begin
					first_q <= new_q;
					cnt_q   <= cnt_q + CW'(1);
				end
				A_DEL_HEAD: begin
					first_q <= link_rdata;
					sp_q    <= sp_q + CW'(1);
					cnt_q   <= cnt_q - CW'(1);
				end
				A_DEL_M2: begin
					sp_q  <= sp_q + CW'(1);
					cnt_q <= cnt_q - CW'(1);
				end
				A_CLEAR: begin
					// all slots free at once: nothing handed out, stack empty
					first_q <= '0;
					cnt_q   <= '0;
					hwm_q   <= '0;
					sp_q    <= '0;
				end
				default: ;
			endcase
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	//------------------------------------------------------------------
	// Item, walk and result registers
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (cw.act)
			A_IDLE: begin
				if (in_fire) begin
					op_q  <= op_t'(req.opcode);
					pos_q <= req.position;
					val_q <= req.value;
				end
			end
			A_DECODE: begin
				status_q <= dec_status;
				ep0_q    <= (ep == '0);
				wt_q     <= dec_wt;
				cur_q    <= first_q;
				rv_q     <= '0;
			end
			A_ALLOC: begin
				pop_q <= (sp_q != '0);
				new_q <= hwm_q[SW-1:0];
			end
			A_SETNEW: begin
				if (pop_q) new_q <= fs_rdata;
			end
			A_WSTART: k_q <= wt_q - CW'(1);
			A_WSTEP: begin
				cur_q <= link_rdata;
				k_q   <= k_q - CW'(1);
			end
			A_DEL_M1:   new_q <= link_rdata;
			A_DEL_HEAD: rv_q  <= val_rdata;
			A_DEL_M2:   rv_q  <= val_rdata;
			A_TAKE_RV:  rv_q  <= val_rdata;
			default: ;
		endcase
		if (resp_load) begin
			out_status_q <= status_q;
			out_value_q  <= rv_q;
			out_count_q  <= cnt_q;
		end
	end

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	// Slots in use equal slots handed out minus slots on the free stack.
	a_slot_acct: assert property (@(posedge clk) disable iff (!arst_n)
		(step == S_IDLE) |-> (cnt_q == hwm_q - sp_q))
		else $error("slot accounting mismatch");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("count above capacity");

	a_resp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step == S_RESP))
		else $error("result loaded outside response step");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(step == S_IWL || step == S_DWL || step == S_RWL) |-> (k_q < CW'(CAPACITY)))
		else $error("walk counter out of range");

endmodule

[bench/indexed_list_engine_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for indexed_list_engine_unit: directed script, then random list traffic.
// Replies are checked against a flat-array shadow of the list. Needs ile_pkg, ile_if, the RTL.
module indexed_list_engine_unit_tb;
	import ile_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 12;
	localparam int LIST_DEPTH       = CAPACITY_DEF;
	localparam int RANDOM_PER_PHASE = 200;
	localparam int LONG_HOLD        = 300;   // receiver hold-off, long enough to back up the input
	localparam int TAIL_CYCLES      = 60;    // idle time after the last reply, before the run ends
	localparam int WATCHDOG_LIMIT   = 5000;  // cycles with no handshake on either channel

	// Opcode 7 has no name in the package; the block treats it like a length report.
	localparam logic [OPCODE_WIDTH-1:0] OP_RESERVED = 3'd7;

	localparam logic [31:0] V_MIN  = 32'h8000_0000;
	localparam logic [31:0] V_MAX  = 32'h7fff_ffff;
	localparam logic [31:0] V_NEG1 = 32'hffff_ffff;

	typedef struct packed {
		status_t     status;
		logic [31:0] read_value;
		logic [5:0]  count;
	} reply_t;

	// One script row; rows with typed set carry their reply, the rest go through the shadow.
	// A row with reps > 1 repeats its opcode with random values.
	typedef struct packed {
		logic [OPCODE_WIDTH-1:0] opc;
		logic [POS_WIDTH-1:0]    pos;
		logic [31:0]             val;
		logic [5:0]              reps;
		logic                    typed;
		reply_t                  reply;
	} script_row_t;

	typedef enum int {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

	localparam int NUM_ROWS = 29;
	localparam script_row_t SCRIPT [NUM_ROWS] = '{
		// empty list: length, bad index and empty refusals
		'{OP_LENGTH,    6'd0,  32'd0,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd0}},
		'{OP_READ_AT,   6'd0,  32'd0,    6'd1,  1'b1, '{ST_BAD_INDEX,     32'd0, 6'd0}},
		'{OP_DELETE_AT, 6'd63, 32'd0,    6'd1,  1'b1, '{ST_BAD_INDEX,     32'd0, 6'd0}},
		'{OP_HEAD_INS,  6'd0,  32'd5,    6'd1,  1'b1, '{ST_EMPTY_REFUSED, 32'd0, 6'd0}},
		'{OP_TAIL_INS,  6'd0,  32'd5,    6'd1,  1'b1, '{ST_EMPTY_REFUSED, 32'd0, 6'd0}},
		'{OP_INSERT_AT, 6'd1,  32'd5,    6'd1,  1'b1, '{ST_BAD_INDEX,     32'd0, 6'd0}},
		// build [MAX, MIN, -1, 0] using every insert flavor
		'{OP_INSERT_AT, 6'd0,  V_MIN,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd1}},
		'{OP_HEAD_INS,  6'd0,  V_MAX,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd2}},
		'{OP_TAIL_INS,  6'd0,  V_NEG1,   6'd1,  1'b1, '{ST_OK,            32'd0, 6'd3}},
		'{OP_INSERT_AT, 6'd3,  32'd0,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd4}},
		'{OP_INSERT_AT, 6'd5,  32'd1,    6'd1,  1'b1, '{ST_BAD_INDEX,     32'd0, 6'd4}},
		'{OP_READ_AT,   6'd0,  32'd0,    6'd1,  1'b1, '{ST_OK,            V_MAX, 6'd4}},
		'{OP_READ_AT,   6'd3,  32'd0,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd4}},
		'{OP_READ_AT,   6'd63, 32'd0,    6'd1,  1'b1, '{ST_BAD_INDEX,     32'd0, 6'd4}},
		'{OP_DELETE_AT, 6'd1,  32'd0,    6'd1,  1'b1, '{ST_OK,            V_MIN, 6'd3}},
		'{OP_RESERVED,  6'd0,  32'd0,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd3}},
		'{OP_INSERT_AT, 6'd2,  32'h1234_5678, 6'd1, 1'b0, '{ST_OK,        32'd0, 6'd0}},
		'{OP_DELETE_AT, 6'd3,  32'd0,    6'd1,  1'b0, '{ST_OK,            32'd0, 6'd0}},
		'{OP_CLEAR,     6'd0,  32'd0,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd0}},
		// fill to capacity, then hit the full list from every side
		'{OP_INSERT_AT, 6'd0,  32'd1,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd1}},
		'{OP_TAIL_INS,  6'd0,  32'd0,    6'd31, 1'b0, '{ST_OK,            32'd0, 6'd0}},
		'{OP_TAIL_INS,  6'd0,  32'd9,    6'd1,  1'b1, '{ST_FULL,          32'd0, 6'd32}},
		'{OP_HEAD_INS,  6'd0,  32'd9,    6'd1,  1'b1, '{ST_FULL,          32'd0, 6'd32}},
		'{OP_INSERT_AT, 6'd33, 32'd9,    6'd1,  1'b1, '{ST_BAD_INDEX,     32'd0, 6'd32}},
		'{OP_INSERT_AT, 6'd32, 32'd9,    6'd1,  1'b1, '{ST_FULL,          32'd0, 6'd32}},
		'{OP_READ_AT,   6'd31, 32'd0,    6'd1,  1'b0, '{ST_OK,            32'd0, 6'd0}},
		'{OP_DELETE_AT, 6'd31, 32'd0,    6'd1,  1'b0, '{ST_OK,            32'd0, 6'd0}},
		'{OP_DELETE_AT, 6'd0,  32'd0,    6'd1,  1'b0, '{ST_OK,            32'd0, 6'd0}},
		'{OP_CLEAR,     6'd0,  32'd0,    6'd1,  1'b1, '{ST_OK,            32'd0, 6'd0}}
	};

	logic clk = 1'b0;
	logic arst_n;

	ile_req_if #(.VALUE_WIDTH(32)) req ();
	ile_rsp_if #(.VALUE_WIDTH(32)) rsp ();

	indexed_list_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the list contents, position order, plus replies not yet seen.
	logic [31:0] shadow_vals [LIST_DEPTH];
	int          shadow_len = 0;
	int          peak_len = 0;
	reply_t      awaited_replies [$];

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_requests = 0;   // bumped by the stimulus, served by the receiver
	int mismatches = 0;
	int sent_count = 0;
	int replies_checked = 0;
	int status_tally [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	// Applies one accepted request to the shadow list and returns the reply it must produce.
	// Position checks come before the capacity check, as in the block.
	function automatic reply_t apply_request(input logic [OPCODE_WIDTH-1:0] opc,
			input logic [POS_WIDTH-1:0] pos, input logic [31:0] val);
		reply_t r;
		int     p;
		logic   ins;
		r.status     = ST_OK;
		r.read_value = '0;
		p            = int'(pos);
		ins          = 1'b0;
		case (opc)
			OP_HEAD_INS, OP_TAIL_INS: begin
				// head/tail never start a list; only insert-at does
				if (shadow_len == 0) begin
					r.status = ST_EMPTY_REFUSED;
				end else begin
					ins = 1'b1;
					p   = (opc == OP_HEAD_INS) ? 0 : shadow_len;
				end
			end
			OP_INSERT_AT: begin
				if (p > shadow_len) r.status = ST_BAD_INDEX;
				else ins = 1'b1;
			end
			OP_DELETE_AT: begin
				if (p >= shadow_len) begin
					r.status = ST_BAD_INDEX;
				end else begin
					r.read_value = shadow_vals[p];
					for (int k = p; k < shadow_len - 1; k++) shadow_vals[k] = shadow_vals[k + 1];
					shadow_len--;
				end
			end
			OP_READ_AT: begin
				if (p >= shadow_len) r.status = ST_BAD_INDEX;
				else r.read_value = shadow_vals[p];
			end
			OP_CLEAR: shadow_len = 0;
			default: ;   // length report and the reserved opcode change nothing
		endcase
		if (ins) begin
			if (shadow_len >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				for (int k = shadow_len; k > p; k--) shadow_vals[k] = shadow_vals[k - 1];
				shadow_vals[p] = val;
				shadow_len++;
			end
		end
		if (shadow_len > peak_len) peak_len = shadow_len;
		r.count = 6'(shadow_len);
		return r;
	endfunction

	// Offers one item from the falling edge, with random idle cycles first, and
	// records its reply once the block takes it.
	task automatic offer(input logic [OPCODE_WIDTH-1:0] opc, input logic [POS_WIDTH-1:0] pos,
			input logic [31:0] val, input logic typed, input reply_t typed_reply);
		reply_t r;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid    <= 1'b1;
		req.opcode   <= opc;
		req.position <= pos;
		req.value    <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		r = apply_request(opc, pos, val);
		awaited_replies.push_back(typed ? typed_reply : r);
		sent_count++;
	endtask

	// Receiver: random ready, or a long hold-off when the stimulus asks for one.
	int hold_served = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp.ready <= 1'b0;
			hold_left--;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = LONG_HOLD - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Reply checker: in-order against the oldest awaited reply.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_replies.size() == 0) begin
				$error("unexpected reply: status %0d read_value %h count %0d",
					rsp.status, rsp.read_value, rsp.count);
				mismatches++;
			end else begin
				want = awaited_replies.pop_front();
				replies_checked++;
				status_tally[want.status]++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, rsp.read_value);
					mismatches++;
				end
				if (rsp.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, rsp.count);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a stuck handshake on both channels ends the run.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles, %0d replies outstanding",
				quiet_cycles, awaited_replies.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		script_row_t             row;
		trend_t                  trend;
		logic [OPCODE_WIDTH-1:0] opc;
		logic [POS_WIDTH-1:0]    pos;
		logic [31:0]             val;
		int                      pick;
		int                      ins_share;
		int                      del_share;

		arst_n       = 1'b0;
		req.valid    = 1'b0;
		req.opcode   = '0;
		req.position = '0;
		req.value    = '0;
		rsp.ready    = 1'b0;
		trend        = TREND_GROW;
		src_idle_pct = 24;
		snk_idle_pct = 85;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed script
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = SCRIPT[i];
			for (int n = 0; n < row.reps; n++) begin
				offer(row.opc, row.pos, (row.reps > 1) ? 32'($urandom()) : row.val,
					row.typed, row.reply);
			end
		end

		// Random traffic in three idle regimes: slow receiver, slow sender, no idling.
		// Each regime ends with the sender parked until every reply is back.
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 85 : 0;
			snk_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 24 : 0;
			// full-rate sender against a stalled receiver: backs up into the input
			if (phase == 2) hold_requests++;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				// trends of 40 items so the list swings between empty and full
				if (i % 40 == 0) trend = trend_t'($urandom_range(2));
				ins_share = (trend == TREND_GROW) ? 80 : (trend == TREND_SHRINK) ? 20 : 45;
				del_share = (trend == TREND_GROW) ? 8 : (trend == TREND_SHRINK) ? 60 : 30;
				case ($urandom_range(9))
					0: val = V_MIN;
					1: val = V_MAX;
					2: val = 32'd0;
					3: val = V_NEG1;
					default: val = $urandom();
				endcase
				pos  = 6'($urandom_range(63));
				pick = $urandom_range(99);
				if (pick < 2) opc = OP_CLEAR;
				else if (pick < 4) opc = OP_LENGTH;
				else if (pick < 5) opc = OP_RESERVED;
				else if (pick < 5 + ins_share) begin
					case ($urandom_range(2))
						0: opc = OP_HEAD_INS;
						1: opc = OP_TAIL_INS;
						default: opc = OP_INSERT_AT;
					endcase
					// an empty list only grows through insert-at; keep a few refusals
					if (shadow_len == 0 && $urandom_range(9) != 0) opc = OP_INSERT_AT;
				end else if (pick < 5 + ins_share + del_share) opc = OP_DELETE_AT;
				else opc = OP_READ_AT;
				// mostly legal positions; the rest spread over the whole field
				if ($urandom_range(9) < 8) begin
					if (opc == OP_INSERT_AT) pos = 6'($urandom_range(shadow_len, 0));
					else if (shadow_len > 0) pos = 6'($urandom_range(shadow_len - 1, 0));
				end
				offer(opc, pos, val, 1'b0, '0);
			end
			@(negedge clk);
			req.valid <= 1'b0;
			while (awaited_replies.size() != 0) @(posedge clk);
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests, %0d replies checked, list length peaked at %0d",
			sent_count, replies_checked, peak_len);
		$display("replies: %0d ok, %0d bad index, %0d empty refused, %0d full, %0d mismatches",
			status_tally[ST_OK], status_tally[ST_BAD_INDEX], status_tally[ST_EMPTY_REFUSED],
			status_tally[ST_FULL], mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
